// File: rtl/sha0_hash_engine_top_macros.svh
// Assertion macros for the SHA-0 hash engine checker.
// Needs aclk and aresetn in the scope of each use.
`ifndef SHA0_HASH_ENGINE_TOP_MACROS_SVH
`define SHA0_HASH_ENGINE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define SHA0_CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SHA0_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define SHA0_CHK_NEXT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sha0_pkg.sv
// Shared types, constants and round functions of the SHA-0 hash engine.
// No dependencies; used by every module of the engine.
`default_nettype none

package sha0_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_END      = 2'd1,
        KIND_BYTE_END = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        item_kind_t kind;
    } queue_item_t;

    typedef struct packed {
        logic        shift_en;
        logic [31:0] shift_word;
        logic        start;
        logic        chain_init;
        logic [2:0]  rd_index;
    } cmp_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [31:0] digest_word;
    } cmp_stat_t;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_MARK_BYTE   = 8'h80;
    localparam logic [5:0] FILL_LAST       = 6'd63;
    localparam logic [5:0] LEN_START       = 6'd56;
    localparam logic [6:0] ROUND_LAST      = 7'd79;
    localparam logic [6:0] ROUND_SCHED     = 7'd16;
    localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        priority if (t < 7'd20) begin
            round_k = K_R0;
        end else if (t < 7'd40) begin
            round_k = K_R1;
        end else if (t < 7'd60) begin
            round_k = K_R2;
        end else begin
            round_k = K_R3;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        priority if (t < 7'd20) begin
            round_f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            round_f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            round_f = (b & c) | (b & d) | (c & d);
        end else begin
            round_f = b ^ c ^ d;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/sha0_front.sv
// Input side of the SHA-0 engine: classifies stream beats and queues them.
// Depends on sha0_pkg for the queue item type.
`default_nettype none

module sha0_front import sha0_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,
    output logic             q_valid,
    output queue_item_t      q_item,
    input  wire logic        q_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    queue_item_t      item_in;

    always_comb begin
        item_in.data_byte = s_tdata;
        unique case ({s_tuser[0], s_tlast})
            2'b10:   item_in.kind = KIND_BYTE;
            2'b01:   item_in.kind = KIND_END;
            2'b11:   item_in.kind = KIND_BYTE_END;
            default: item_in.kind = KIND_BYTE;
        endcase
    end

    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // drop beats that carry neither a byte nor an end mark
    assign push = s_tvalid && s_tready && (s_tuser[0] || s_tlast);
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sha0_compress.sv
// SHA-0 compression unit: chaining values, schedule shift line, one round a cycle.
// Depends on sha0_pkg for constants, round functions and control structs.
`default_nettype none

module sha0_compress import sha0_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cmp_ctrl_t ctrl,
    output cmp_stat_t      stat
);

    logic [31:0] chain_reg [5];
    logic [31:0] win_reg   [16];
    logic [31:0] wv_reg    [5];
    logic [6:0]  round_reg;
    logic        busy_reg;
    logic        add_reg;

    logic [31:0] w, f, k, tmp;

    always_comb begin
        if (round_reg < ROUND_SCHED) begin
            w = win_reg[0];
        end else begin
            w = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        end
        f   = round_f(round_reg, wv_reg[1], wv_reg[2], wv_reg[3]);
        k   = round_k(round_reg);
        tmp = rotl(wv_reg[0], 5) + f + wv_reg[4] + k + w;
    end

    always_comb begin
        stat.done = add_reg;
        unique case (ctrl.rd_index)
            3'd0:    stat.digest_word = chain_reg[0];
            3'd1:    stat.digest_word = chain_reg[1];
            3'd2:    stat.digest_word = chain_reg[2];
            3'd3:    stat.digest_word = chain_reg[3];
            default: stat.digest_word = chain_reg[4];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            add_reg   <= 1'b0;
            round_reg <= '0;
        end else begin
            add_reg <= busy_reg && (round_reg == ROUND_LAST);
            if (ctrl.start) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end else if (busy_reg) begin
                if (round_reg == ROUND_LAST) begin
                    busy_reg  <= 1'b0;
                    round_reg <= '0;
                end else begin
                    round_reg <= round_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.chain_init) begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
        end else if (add_reg) begin
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= chain_reg[i] + wv_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en || busy_reg) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= ctrl.shift_en ? ctrl.shift_word : w;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            for (int i = 0; i < 5; i++) begin
                wv_reg[i] <= chain_reg[i];
            end
        end else if (busy_reg) begin
            wv_reg[0] <= tmp;
            wv_reg[1] <= wv_reg[0];
            wv_reg[2] <= rotl(wv_reg[1], 30);
            wv_reg[3] <= wv_reg[2];
            wv_reg[4] <= wv_reg[3];
        end
    end

endmodule

`default_nettype wire

// File: rtl/sha0_pad.sv
// Back-end sequencer: block assembly, padding, length field and digest output.
// Depends on sha0_pkg; drives sha0_compress through the control struct.
`default_nettype none

module sha0_pad import sha0_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire queue_item_t  q_item,
    output logic              q_ready,
    output cmp_ctrl_t         ctrl,
    input  wire cmp_stat_t    stat,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // [31:0] digest_word
    output logic [2:0]        m_tuser,   // [2:0] word_index
    output logic              m_tlast
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MARK = 6'b000010,
        S_ZERO = 6'b000100,
        S_LEN  = 6'b001000,
        S_WAIT = 6'b010000,
        S_OUT  = 6'b100000
    } pad_state_t;

    pad_state_t  state_reg, state_next;
    pad_state_t  ret_reg, ret_next, wrap_ret;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] acc_reg, acc_next;
    logic [2:0]  emit_reg, emit_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;
    logic        put_en;
    logic [7:0]  put_val;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        wrap_ret       = S_IDLE;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        acc_next       = acc_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        q_ready        = 1'b0;
        put_en         = 1'b0;
        put_val        = '0;
        ctrl           = '0;
        ctrl.rd_index  = emit_reg;

        unique case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    unique case (q_item.kind)
                        KIND_BYTE: begin
                            put_en    = 1'b1;
                            put_val   = q_item.data_byte;
                            bits_next = bits_reg + 64'd8;
                            wrap_ret  = S_IDLE;
                        end
                        KIND_BYTE_END: begin
                            put_en     = 1'b1;
                            put_val    = q_item.data_byte;
                            bits_next  = bits_reg + 64'd8;
                            wrap_ret   = S_MARK;
                            state_next = S_MARK;
                        end
                        default: begin
                            state_next = S_MARK;
                        end
                    endcase
                end
            end
            S_MARK: begin
                put_en     = 1'b1;
                put_val    = PAD_MARK_BYTE;
                wrap_ret   = S_ZERO;
                state_next = S_ZERO;
            end
            S_ZERO: begin
                wrap_ret = S_ZERO;
                if (fill_reg == LEN_START) begin
                    state_next = S_LEN;
                end else begin
                    put_en = 1'b1;
                end
            end
            S_LEN: begin
                put_en   = 1'b1;
                put_val  = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
                wrap_ret = S_OUT;
            end
            S_WAIT: begin
                if (stat.done) begin
                    state_next = ret_reg;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = stat.digest_word;
                    out_idx_next   = emit_reg;
                    out_last_next  = (emit_reg == LAST_WORD_INDEX);
                    if (emit_reg == LAST_WORD_INDEX) begin
                        emit_next       = '0;
                        ctrl.chain_init = 1'b1;
                        fill_next       = '0;
                        bits_next       = '0;
                        state_next      = S_IDLE;
                    end else begin
                        emit_next = emit_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // gather bytes into big-endian words; compress on the last byte of a block
        if (put_en) begin
            acc_next  = {acc_reg[15:0], put_val};
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] == 2'b11) begin
                ctrl.shift_en   = 1'b1;
                ctrl.shift_word = {acc_reg, put_val};
            end
            if (fill_reg == FILL_LAST) begin
                ctrl.start = 1'b1;
                ret_next   = wrap_ret;
                state_next = S_WAIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// File: rtl/sha0_hash_engine_top.sv
// Top level of the SHA-0 hash engine: input queue, padding sequencer, compression unit.
// Depends on sha0_pkg, sha0_front, sha0_pad and sha0_compress.
//
//   channel   direction  tdata              tuser            tlast
//   s_        in         [7:0] data_byte    [0] byte_present end_of_message
//   m_        out        [31:0] digest_word [2:0] word_index last_word
//
// A 64-byte block is gathered one byte a cycle, except while a block compresses or the
// queue is empty, and is then compressed in the one-round-a-cycle unit (80 rounds, one
// chaining add). Message end, also on an end beat without a byte, adds the 0x80 mark,
// zero bytes and the length field, compresses each padded block, then five output beats.
// The input queue takes QUEUE_DEPTH beats while the back end is busy.
// Reset is synchronous, active low, and needs a single cycle; there is no clear sweep.
// A stalled output beat holds; the back end stalls only at the next digest word.
`default_nettype none

module sha0_hash_engine_top import sha0_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast
);

    logic        q_valid;
    logic        q_ready;
    queue_item_t q_item;
    cmp_ctrl_t   cmp_ctrl;
    cmp_stat_t   cmp_stat;

    sha0_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    sha0_pad u_pad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready),
        .ctrl     (cmp_ctrl),
        .stat     (cmp_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha0_compress u_compress (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cmp_ctrl),
        .stat    (cmp_stat)
    );

endmodule

`default_nettype wire

// File: rtl/sha0_checker.sv
// Port-level checker for the SHA-0 hash engine, bound to the top level.
// Depends on sha0_pkg and sha0_hash_engine_top_macros.svh.
`default_nettype none

`include "sha0_hash_engine_top_macros.svh"

module sha0_checker import sha0_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    logic [2:0] exp_idx_reg, exp_idx_next;

    always_comb begin
        exp_idx_next = exp_idx_reg;
        if (m_tvalid && m_tready) begin
            exp_idx_next = m_tlast ? 3'd0 : exp_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else begin
            exp_idx_reg <= exp_idx_next;
        end
    end

    `SHA0_CHK_IMPL(a_word_order, m_tvalid, m_tuser == exp_idx_reg, "digest word out of order")
    `SHA0_CHK_IMPL(a_last_word, m_tvalid, m_tlast == (m_tuser == LAST_WORD_INDEX), "tlast misplaced")
    `SHA0_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")
    `SHA0_CHK_NEXT_ANY(a_reset_state, !aresetn, s_tready && !m_tvalid, "bad state after reset")

endmodule

bind sha0_hash_engine_top sha0_checker u_checker (.*);

`default_nettype wire

// File: dv/sha0_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker for the SHA-0 hash engine: follows the accepted byte stream, works out
// each digest with its own SHA-0 model and compares every result beat with it.
// Depends on the port signals of sha0_hash_engine_top only.
module sha0_digest_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [31:0] digest_word
    input  wire logic [2:0]  m_tuser,   // [2:0] word_index
    input  wire logic        m_tlast,
    output int unsigned      mismatch_count,
    output int unsigned      pending_beats,
    output int unsigned      checked_beats
);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;
    localparam logic [31:0] RK_0 = 32'h5A827999;
    localparam logic [31:0] RK_1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK_2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK_3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [2:0]  LAST_IDX = 3'd4;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    logic [31:0]  hv [5];
    logic [7:0]   blk [BLOCK_BYTES];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_beat_t digest_q [$];
    digest_beat_t want;
    digest_beat_t got;
    int unsigned  fails;
    int unsigned  seen;

    function automatic void restart_chain();
        hv[0]   = IV_A;
        hv[1]   = IV_B;
        hv[2]   = IV_C;
        hv[3]   = IV_D;
        hv[4]   = IV_E;
        fill    = 0;
        bit_len = '0;
    endfunction

    function automatic void compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        int unsigned t;
        a = hv[0];
        b = hv[1];
        c = hv[2];
        d = hv[3];
        e = hv[4];
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            end else begin
                wt = w[(t+13) % 16] ^ w[(t+8) % 16] ^ w[(t+2) % 16] ^ w[t % 16];
            end
            w[t % 16] = wt;
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = RK_0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = RK_1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK_2;
            end else begin
                f = b ^ c ^ d;
                k = RK_3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        hv[0] = hv[0] + a;
        hv[1] = hv[1] + b;
        hv[2] = hv[2] + c;
        hv[3] = hv[3] + d;
        hv[4] = hv[4] + e;
    endfunction

    function automatic void absorb(input logic [7:0] data, input logic present,
                                   input logic fin);
        int unsigned i;
        logic [63:0] len_bits;
        if (present) begin
            blk[fill] = data;
            fill = (fill + 1) % BLOCK_BYTES;
            bit_len = bit_len + 64'd8;
            if (fill == 0) begin
                compress();
            end
        end
        if (fin) begin
            len_bits = bit_len;
            blk[fill] = PAD_BYTE;
            fill++;
            if (fill > LEN_POS) begin
                while (fill < BLOCK_BYTES) begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                compress();
                fill = 0;
            end
            while (fill < LEN_POS) begin
                blk[fill] = 8'h00;
                fill++;
            end
            for (i = 0; i < 8; i++) begin
                blk[LEN_POS + i] = len_bits[63 - 8*i -: 8];
            end
            compress();
            for (i = 0; i < 5; i++) begin
                digest_q.push_back('{word: hv[i], idx: 3'(i), last: (3'(i) == LAST_IDX)});
            end
            restart_chain();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_chain();
            digest_q.delete();
            pending_beats <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{word: m_tdata, idx: m_tuser, last: m_tlast};
                seen++;
                if (digest_q.size() == 0) begin
                    fails++;
                    $display("%0t: digest beat with nothing expected: word %h index %0d last %0b",
                             $time, got.word, got.idx, got.last);
                end else begin
                    want = digest_q.pop_front();
                    if (got.word !== want.word || got.idx !== want.idx ||
                        got.last !== want.last) begin
                        fails++;
                        $display("%0t: digest beat mismatch: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                                 $time, want.word, want.idx, want.last,
                                 got.word, got.idx, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                absorb(s_tdata, s_tuser[0], s_tlast);
            end
            pending_beats <= digest_q.size();
        end
        mismatch_count <= fails;
        checked_beats  <= seen;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for sha0_hash_engine_top: reset, byte-stream stimulus, output back-pressure
// and the verdict. Depends on the RTL and on sha0_digest_checker.
module tb_top;

    localparam int unsigned ITEM_TARGET  = 300;
    localparam int unsigned MIN_MESSAGES = 8;
    localparam int unsigned HOLD_AT      = 12;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned TAIL_CYCLES  = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int unsigned mismatch_count;
    int unsigned pending_beats;
    int unsigned checked_beats;
    int unsigned items_sent;
    int unsigned messages_sent;
    int unsigned bytes_sent;
    int unsigned random_messages;
    int unsigned idle_cycles;
    bit          sender_burst;

    sha0_hash_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha0_digest_checker digest_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats),
        .checked_beats  (checked_beats)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic offer(input logic [7:0] data, input logic present, input logic fin);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= data;
        s_tuser[0] <= present;
        s_tlast    <= fin;
        do @(posedge aclk); while (!s_tready);
        if (present || fin) items_sent++;
        if (present) bytes_sent++;
        if (fin) messages_sent++;
    endtask

    task automatic send_random_message(input int unsigned len);
        bit          end_on_byte;
        int unsigned i;
        sender_burst = ($urandom_range(0, 3) == 0);
        end_on_byte  = (len != 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            offer(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) begin
            offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    function automatic int unsigned pick_length();
        int unsigned edges [7];
        edges = '{54, 55, 56, 57, 63, 64, 65};
        case ($urandom_range(0, 9))
            6, 7:    pick_length = edges[$urandom_range(0, 6)];
            8:       pick_length = $urandom_range(13, 130);
            9:       pick_length = $urandom_range(0, 3);
            default: pick_length = $urandom_range(0, 12);
        endcase
    endfunction

    // output side: random stalls, bursts, and one long hold-off to back the engine up
    initial begin
        int unsigned gap;
        int unsigned beats;
        bit          burst;
        beats = 0;
        burst = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 13);
            if (beats == HOLD_AT) gap = HOLD_CYCLES;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats++;
            if (beats % 25 == 0) burst = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("sha0_hash_engine_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= 8'h00;
        s_tuser      <= 1'b0;
        s_tlast      <= 1'b0;
        idle_cycles  <= 0;
        items_sent      = 0;
        messages_sent   = 0;
        bytes_sent      = 0;
        random_messages = 0;
        sender_burst    = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty message, ignored beat, one-byte messages at both extremes, then "abc"
        offer(8'hA5, 1'b0, 1'b1);
        offer(8'hFF, 1'b0, 1'b0);
        offer(8'h00, 1'b1, 1'b1);
        offer(8'hFF, 1'b1, 1'b1);
        offer(8'h61, 1'b1, 1'b0);
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b1);
        // end on a beat of its own, after an ignored beat; then empty messages and a burst-sent message
        offer(8'h00, 1'b1, 1'b0);
        offer(8'hFF, 1'b1, 1'b0);
        offer(8'h5A, 1'b0, 1'b0);
        offer(8'h3C, 1'b0, 1'b1);
        offer(8'h00, 1'b0, 1'b1);
        sender_burst = 1'b1;
        offer(8'h80, 1'b1, 1'b0);
        offer(8'h7F, 1'b1, 1'b0);
        offer(8'h01, 1'b1, 1'b1);
        offer(8'hC3, 1'b0, 1'b1);

        while (items_sent < ITEM_TARGET || random_messages < MIN_MESSAGES) begin
            send_random_message(pick_length());
            random_messages++;
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_beats != 0) begin
            $display("%0t: %0d digest beats never arrived", $time, pending_beats);
        end
        $display("Covered %0d messages, %0d bytes in %0d input items, incl. padding edges;",
                 messages_sent, bytes_sent, items_sent);
        $display("checked %0d digest beats under random stalls and one long output hold-off.",
                 checked_beats);
        if (mismatch_count == 0 && pending_beats == 0) begin
            $display("sha0_hash_engine_top regression: pass");
        end else begin
            $display("sha0_hash_engine_top regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/sha0_pkg.sv
rtl/sha0_front.sv
rtl/sha0_compress.sv
rtl/sha0_pad.sv
rtl/sha0_hash_engine_top.sv
rtl/sha0_checker.sv
dv/sha0_digest_checker.sv
dv/tb_top.sv
